>>> hdl/iormq_pkg.sv
// Shared types and codes of the I/O request merge queue.
`timescale 1ns / 1ps
package iormq_pkg;

   localparam int START_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_APPENDED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MERGED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DRAINED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_APPEND,
      ST_REPLY,
      ST_DR_RD,
      ST_DR_EV,
      ST_DR_EMIT
   } state_type;

endpackage

>>> hdl/iormq_if.sv
// Handshake channels for request items and result items.
`timescale 1ns / 1ps
interface iormq_req_if;
   import iormq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [START_W-1:0]   start_block;
   logic [COUNT_W-1:0]   block_count;
   logic [OP_W-1:0]      operation;

   modport source (output valid, kind, start_block, block_count, operation, input ready);
   modport sink   (input valid, kind, start_block, block_count, operation, output ready);
endinterface

interface iormq_rsp_if;
   import iormq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [START_W-1:0]   out_start;
   logic [COUNT_W-1:0]   out_count;
   logic [OP_W-1:0]      out_operation;
   logic                 last;

   modport source (output valid, status, out_start, out_count, out_operation, last,
                   input ready);
   modport sink   (input valid, status, out_start, out_count, out_operation, last,
                   output ready);
endinterface

>>> hdl/io_request_merge_queue.sv
// I/O request merge queue: top level with the sequencer around the entry store.
//
// Request channel req_ch takes insert items (kind 0) and drain items (kind 1).
// One item is worked on at a time; req_ch.ready is high only while idle.
// An insert scans the table in order, reading and then evaluating each
// entry. Each merge removes the matched entry by shifting the tail down
// (each moved entry is read, then written one place lower) and the scan
// restarts from entry 0 with the union extent. The item ends with an
// append and one result: appended, merged or table full.
// A drain gives one result per stored entry in start block order (ties in
// table order), last set on the final one, then empties the table. Each
// result takes a pass over the table. An empty table gives one result,
// status table empty.
// Results sit in an output register; work carries on while one waits, and
// the sequencer holds when the next result finds the register still full.
// Reset empties the table at once; stored data is not cleared.
`timescale 1ns / 1ps
module io_request_merge_queue #(
   parameter int TABLE_DEPTH = 32,
   parameter int MERGE_LIMIT = 64
) (
   input  logic         clock,
   input  logic         reset,
   iormq_req_if.sink    req_ch,
   iormq_rsp_if.source  rsp_ch
);
   import iormq_pkg::*;

   localparam int LW = $clog2(MERGE_LIMIT + 1);
   localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int FW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = START_W + CW + OP_W;

   state_type state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [FW-1:0] pos_ff, pos_in;
   logic [FW-1:0] nemit_ff, nemit_in;
   logic [31:0] ns_ff, ns_in;
   logic [CW-1:0] nc_ff, nc_in;
   logic [1:0] nop_ff, nop_in;
   logic merged_ff, merged_in;
   logic [STATUS_W-1:0] pend_ff, pend_in;
   logic [31:0] best_s_ff, best_s_in, prev_s_ff, prev_s_in;
   logic [CW-1:0] best_c_ff, best_c_in;
   logic [1:0] best_o_ff, best_o_in;
   logic [FW-1:0] best_i_ff, best_i_in, prev_i_ff, prev_i_in;
   logic best_v_ff, best_v_in, prev_v_ff, prev_v_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_start_ff, rsp_start_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [OP_W-1:0] rsp_op_ff, rsp_op_in;
   logic rsp_last_ff, rsp_last_in;

   logic mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata, mem_rdata;
   logic [31:0] rd_s;
   logic [CW-1:0] rd_c;
   logic [1:0] rd_o;
   logic m_hit;
   logic [31:0] m_lo;
   logic [CW-1:0] m_cnt;
   logic [FW:0] idx_nx, pos_nx2, fill_w, nemit_nx;
   logic slot_free, req_fire, last_emit, cand;

   assign {rd_s, rd_c, rd_o} = mem_rdata;
   assign idx_nx   = {1'b0, idx_ff} + (FW+1)'(1);
   assign pos_nx2  = {1'b0, pos_ff} + (FW+1)'(2);
   assign fill_w   = {1'b0, fill_ff};
   assign nemit_nx = {1'b0, nemit_ff} + (FW+1)'(1);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign last_emit = (nemit_nx == fill_w);
   // strictly after the previous output in (start, index) order, and ahead of the best so far
   assign cand = (!prev_v_ff || rd_s > prev_s_ff || (rd_s == prev_s_ff && idx_ff > prev_i_ff))
              && (!best_v_ff || rd_s < best_s_ff);

   iormq_table #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   iormq_merge #(.CW(CW), .MERGE_LIMIT(MERGE_LIMIT)) u_merge (
      .ns  (ns_ff),
      .nc  (nc_ff),
      .nop (nop_ff),
      .es  (rd_s),
      .ec  (rd_c),
      .eop (rd_o),
      .hit (m_hit),
      .lo  (m_lo),
      .cnt (m_cnt)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (fill_ff == '0) begin
                  state_in = (req_ch.kind == KIND_DRAIN) ? ST_REPLY : ST_APPEND;
               end else begin
                  state_in = (req_ch.kind == KIND_DRAIN) ? ST_DR_RD : ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (m_hit) begin
               if (idx_nx < fill_w) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  state_in = (fill_ff == FW'(1)) ? ST_APPEND : ST_SCAN_RD;
               end
            end else begin
               state_in = (idx_nx < fill_w) ? ST_SCAN_RD : ST_APPEND;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = (pos_nx2 < fill_w) ? ST_SHIFT_RD : ST_SCAN_RD;
         ST_APPEND: state_in = ST_REPLY;
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DR_RD: state_in = ST_DR_EV;
         ST_DR_EV: state_in = (idx_nx < fill_w) ? ST_DR_RD : ST_DR_EMIT;
         ST_DR_EMIT: begin
            if (slot_free) begin
               state_in = last_emit ? ST_IDLE : ST_DR_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: memory control and handshakes
   always_comb begin
      req_ch.ready = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[IW-1:0];
      mem_wdata    = mem_rdata;
      mem_raddr    = idx_ff[IW-1:0];
      unique case (state_ff)
         ST_IDLE:     req_ch.ready = 1'b1;
         ST_SHIFT_RD: mem_raddr = IW'(pos_ff + FW'(1));
         ST_SHIFT_WR: mem_we = 1'b1;
         ST_APPEND: begin
            mem_we    = (fill_w < (FW+1)'(TABLE_DEPTH));
            mem_waddr = fill_ff[IW-1:0];
            mem_wdata = {ns_ff, nc_ff, nop_ff};
         end
         default: begin
         end
      endcase
   end

   // working registers
   always_comb begin
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      nemit_in  = nemit_ff;
      ns_in     = ns_ff;
      nc_in     = nc_ff;
      nop_in    = nop_ff;
      merged_in = merged_ff;
      pend_in   = pend_ff;
      best_s_in = best_s_ff;
      best_c_in = best_c_ff;
      best_o_in = best_o_ff;
      best_i_in = best_i_ff;
      best_v_in = best_v_ff;
      prev_s_in = prev_s_ff;
      prev_i_in = prev_i_ff;
      prev_v_in = prev_v_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ns_in     = req_ch.start_block;
               nc_in     = CW'(req_ch.block_count);
               nop_in    = req_ch.operation;
               merged_in = 1'b0;
               idx_in    = '0;
               nemit_in  = '0;
               best_v_in = 1'b0;
               prev_v_in = 1'b0;
               pend_in   = STATUS_EMPTY;
            end
         end
         ST_SCAN_EV: begin
            if (m_hit) begin
               ns_in     = m_lo;
               nc_in     = m_cnt;
               merged_in = 1'b1;
               pos_in    = idx_ff;
               if (!(idx_nx < fill_w)) begin
                  fill_in = fill_ff - FW'(1);
                  idx_in  = '0;
               end
            end else begin
               idx_in = FW'(idx_nx);
            end
         end
         ST_SHIFT_WR: begin
            pos_in = pos_ff + FW'(1);
            if (!(pos_nx2 < fill_w)) begin
               fill_in = fill_ff - FW'(1);
               idx_in  = '0;
            end
         end
         ST_APPEND: begin
            if (fill_w < (FW+1)'(TABLE_DEPTH)) begin
               fill_in = fill_ff + FW'(1);
               pend_in = merged_ff ? STATUS_MERGED : STATUS_APPENDED;
            end else begin
               pend_in = STATUS_FULL;
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               rsp_start_in  = '0;
               rsp_count_in  = '0;
               rsp_op_in     = '0;
               rsp_last_in   = 1'b1;
            end
         end
         ST_DR_EV: begin
            if (cand) begin
               best_s_in = rd_s;
               best_c_in = rd_c;
               best_o_in = rd_o;
               best_i_in = idx_ff;
               best_v_in = 1'b1;
            end
            idx_in = FW'(idx_nx);
         end
         ST_DR_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DRAINED;
               rsp_start_in  = best_s_ff;
               rsp_count_in  = best_c_ff[COUNT_W-1:0];
               rsp_op_in     = best_o_ff;
               rsp_last_in   = last_emit;
               prev_s_in     = best_s_ff;
               prev_i_in     = best_i_ff;
               prev_v_in     = 1'b1;
               best_v_in     = 1'b0;
               idx_in        = '0;
               nemit_in      = FW'(nemit_nx);
               if (last_emit) begin
                  fill_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      nemit_ff      <= nemit_in;
      ns_ff         <= ns_in;
      nc_ff         <= nc_in;
      nop_ff        <= nop_in;
      merged_ff     <= merged_in;
      pend_ff       <= pend_in;
      best_s_ff     <= best_s_in;
      best_c_ff     <= best_c_in;
      best_o_ff     <= best_o_in;
      best_i_ff     <= best_i_in;
      best_v_ff     <= best_v_in;
      prev_s_ff     <= prev_s_in;
      prev_i_ff     <= prev_i_in;
      prev_v_ff     <= prev_v_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.out_start     = rsp_start_ff;
   assign rsp_ch.out_count     = rsp_count_ff;
   assign rsp_ch.out_operation = rsp_op_ff;
   assign rsp_ch.last          = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_w <= (FW+1)'(TABLE_DEPTH))
      else $error("fill level beyond table depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_status_ff))
      else $error("pending item overwritten");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPEND && mem_we |=> fill_ff == $past(fill_ff) + FW'(1))
      else $error("append did not grow the table");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DR_EMIT && slot_free && last_emit |=> fill_ff == '0)
      else $error("drain left entries");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT_RD |-> ({1'b0, pos_ff} + (FW+1)'(1)) < fill_w)
      else $error("shift beyond fill level");

endmodule

>>> hdl/iormq_table.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module iormq_table #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 41
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> hdl/iormq_merge.sv
// Merge test of a request against one stored entry, and the union extent.
`timescale 1ns / 1ps
module iormq_merge #(
   parameter int CW          = 7,
   parameter int MERGE_LIMIT = 64
) (
   input  logic [31:0]   ns,
   input  logic [CW-1:0] nc,
   input  logic [1:0]    nop,
   input  logic [31:0]   es,
   input  logic [CW-1:0] ec,
   input  logic [1:0]    eop,
   output logic          hit,
   output logic [31:0]   lo,
   output logic [CW-1:0] cnt
);
   import iormq_pkg::*;

   logic [32:0] ne, ee, hi;
   logic [CW:0] csum;
   logic        adj;

   always_comb begin
      // ends are kept one bit wider so extents past the top block compare right
      ne   = {1'b0, ns} + 33'(nc);
      ee   = {1'b0, es} + 33'(ec);
      csum = {1'b0, ec} + {1'b0, nc};
      if (nop == OP_READ) begin
         adj = ({1'b0, es} > {1'b0, ns} && {1'b0, es} <= ne)
            || ({1'b0, ns} > {1'b0, es} && {1'b0, ns} <= ee);
      end else begin
         adj = ({1'b0, es} == ne) || ({1'b0, ns} == ee);
      end
      hit = (nop == OP_READ || nop == OP_WRITE) && (eop == nop)
         && (32'(csum) <= 32'(MERGE_LIMIT)) && adj;
      lo  = (es < ns) ? es : ns;
      hi  = (ee > ne) ? ee : ne;
      cnt = CW'(hi - {1'b0, lo});
   end

endmodule

>>> dv/tb_io_request_merge_queue.sv
// Testbench for the I/O request merge queue: merge predictor, scoreboard and drivers.
`timescale 1ns / 1ps

class merge_scoreboard;
   localparam int DEPTH = 32;
   localparam int LIMIT = 64;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] start;
      logic [6:0]  count;
      logic [1:0]  op;
      logic        last;
   } result_t;

   logic [31:0] tbl_start[DEPTH];
   logic [6:0]  tbl_count[DEPTH];
   logic [1:0]  tbl_op[DEPTH];
   int          fill;
   result_t     pending[$];
   int          errors;
   int          checked;
   int          merges;
   int          fulls;

   function new();
      fill = 0;
      errors = 0;
      checked = 0;
      merges = 0;
      fulls = 0;
   endfunction

   function bit mergeable(logic [32:0] ns, logic [32:0] nc, logic [1:0] nop, int i);
      logic [32:0] es;
      logic [32:0] ec;
      es = tbl_start[i];
      ec = tbl_count[i];
      if (nop > iormq_pkg::OP_WRITE || tbl_op[i] != nop) return 0;
      if (ec + nc > LIMIT) return 0;
      if (nop == iormq_pkg::OP_READ)
         return (es > ns && es <= ns + nc) || (ns > es && ns <= es + ec);
      return es == ns + nc || ns == es + ec;
   endfunction

   function void drop(int pos);
      for (int i = pos; i + 1 < fill; i++) begin
         tbl_start[i] = tbl_start[i+1];
         tbl_count[i] = tbl_count[i+1];
         tbl_op[i] = tbl_op[i+1];
      end
      fill--;
   endfunction

   // Predicts the results of one accepted item and queues them.
   function void note_item(logic kind, logic [31:0] s, logic [6:0] c, logic [1:0] op);
      logic [32:0] ns;
      logic [32:0] nc;
      logic [32:0] lo;
      logic [32:0] hi;
      bit merged;
      bit found;
      int order[DEPTH];
      int j;
      if (kind == iormq_pkg::KIND_INSERT) begin
         ns = s;
         nc = c;
         merged = 0;
         found = 1;
         while (found) begin
            found = 0;
            for (int i = 0; i < fill; i++) begin
               if (mergeable(ns, nc, op, i)) begin
                  lo = (tbl_start[i] < ns) ? tbl_start[i] : ns;
                  hi = (tbl_start[i] + tbl_count[i] > ns + nc) ?
                       tbl_start[i] + tbl_count[i] : ns + nc;
                  ns = lo;
                  nc = hi - lo;
                  drop(i);
                  merged = 1;
                  found = 1;
                  break;
               end
            end
         end
         if (fill >= DEPTH) begin
            pending.push_back('{iormq_pkg::STATUS_FULL, 0, 0, 0, 1});
            fulls++;
         end else begin
            tbl_start[fill] = ns[31:0];
            tbl_count[fill] = nc[6:0];
            tbl_op[fill] = op;
            fill++;
            if (merged) merges++;
            pending.push_back('{merged ? iormq_pkg::STATUS_MERGED : iormq_pkg::STATUS_APPENDED,
                                0, 0, 0, 1});
         end
      end else if (fill == 0) begin
         pending.push_back('{iormq_pkg::STATUS_EMPTY, 0, 0, 0, 1});
      end else begin
         // stable insertion sort keeps ties in table order
         for (int i = 0; i < fill; i++) begin
            j = i;
            while (j > 0 && tbl_start[order[j-1]] > tbl_start[i]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (int i = 0; i < fill; i++)
            pending.push_back('{iormq_pkg::STATUS_DRAINED, tbl_start[order[i]],
                                tbl_count[order[i]], tbl_op[order[i]], i + 1 == fill});
         fill = 0;
      end
   endfunction

   function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at result %0d: %s got %0h expected %0h", checked, what, got, want);
   endfunction

   function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
         report("unexpected item, status", 32'(got.status), '0);
         return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.start !== want.start) report("out_start", got.start, want.start);
      if (got.count !== want.count) report("out_count", got.count, want.count);
      if (got.op !== want.op) report("out_operation", got.op, want.op);
      if (got.last !== want.last) report("last", got.last, want.last);
      checked++;
   endfunction
endclass

module tb_io_request_merge_queue;
   import iormq_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   int   idle_pct = 11;
   int   hold_off = 0;
   int   items_sent = 0;

   iormq_req_if req_ch ();
   iormq_rsp_if rsp_ch ();

   io_request_merge_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   merge_scoreboard board = new();

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_io_request_merge_queue NOT OK");
         $finish;
      end
   end

   // sample at the rising edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_item(req_ch.kind, req_ch.start_block, req_ch.block_count,
                         req_ch.operation);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result('{rsp_ch.status, rsp_ch.out_start, rsp_ch.out_count,
                              rsp_ch.out_operation, rsp_ch.last});
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // valid stays high between back-to-back items; idling or wait_drained drops it
   task automatic send(logic kind, logic [31:0] s, logic [6:0] c, logic [1:0] op);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.kind <= kind;
      req_ch.start_block <= s;
      req_ch.block_count <= c;
      req_ch.operation <= op;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic random_item(logic [31:0] base);
      int pick;
      logic [31:0] s;
      pick = $urandom_range(99);
      s = base + $urandom_range(300);
      if (pick < 8)
         send(KIND_DRAIN, $urandom, $urandom, $urandom);
      else if (pick < 15)
         send(KIND_INSERT, $urandom, $urandom, $urandom); // noise, any op and count
      else if (pick < 20)
         send(KIND_INSERT, s, $urandom_range(64, 1), 2'd2 + $urandom_range(1));
      else
         send(KIND_INSERT, s, $urandom_range(24, 1), $urandom_range(1));
   endtask

   initial begin
      logic [31:0] base;
      req_ch.valid = 0;
      req_ch.kind = KIND_INSERT;
      req_ch.start_block = 0;
      req_ch.block_count = 1;
      req_ch.operation = OP_READ;
      rsp_ch.ready = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part
      send(KIND_DRAIN, 0, 0, 0);                         // empty table
      send(KIND_INSERT, 100, 10, OP_READ);
      send(KIND_INSERT, 110, 5, OP_READ);                // read touching
      send(KIND_INSERT, 105, 20, OP_READ);               // read overlap
      send(KIND_INSERT, 100, 4, OP_READ);                // equal start, no merge
      send(KIND_INSERT, 200, 8, OP_WRITE);
      send(KIND_INSERT, 208, 8, OP_WRITE);               // write adjacent
      send(KIND_INSERT, 210, 8, OP_WRITE);               // write overlap, no merge
      send(KIND_INSERT, 190, 10, OP_WRITE);              // write adjacent below, one merge
      send(KIND_INSERT, 300, 64, OP_READ);
      send(KIND_INSERT, 364, 1, OP_READ);                // sum over the limit
      send(KIND_INSERT, 500, 3, 2'd2);                   // unknown ops
      send(KIND_INSERT, 503, 3, 2'd3);
      send(KIND_INSERT, 32'hFFFF_FFF0, 64, OP_READ);     // runs past the top
      send(KIND_INSERT, 32'hFFFF_FFFF, 127, OP_WRITE);   // count out of range
      send(KIND_INSERT, 0, 0, OP_READ);                  // zero count
      send(KIND_DRAIN, 32'hFFFF_FFFF, 7'h7F, 2'd3);
      // fill the table, then a full insert and a merge into a full table
      for (int i = 0; i < 32; i++) send(KIND_INSERT, 1000 + 100 * i, 10, OP_WRITE);
      send(KIND_INSERT, 5000, 1, OP_READ);
      send(KIND_INSERT, 1010, 5, OP_WRITE);
      send(KIND_DRAIN, 0, 0, 0);

      // sender pauses until everything is back
      wait_drained();

      // long receiver hold-off while requests keep coming
      hold_off = 400;
      for (int i = 0; i < 20; i++) random_item(32'd5000);

      for (int n = 0; n < 130; n++) begin
         if (n % 40 == 0) base = $urandom;
         idle_pct = (n >= 80 && n < 120) ? 0 : 11;
         random_item(base);
      end
      send(KIND_DRAIN, 0, 0, 0);
      idle_pct = 11;

      wait_drained();
      repeat (3000) @(negedge clock);
      $display("covered %0d items, %0d results, %0d merges, %0d full rejects",
               items_sent, board.checked, board.merges, board.fulls);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_io_request_merge_queue OK");
      else
         $display("tb_io_request_merge_queue NOT OK");
      $finish;
   end
endmodule

>>> files.f
hdl/iormq_pkg.sv
hdl/iormq_if.sv
hdl/iormq_table.sv
hdl/iormq_merge.sv
hdl/io_request_merge_queue.sv
dv/tb_io_request_merge_queue.sv
